### design/j2s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2s_pkg: shared types and constants
// Field types, stage payload types and reciprocal constants for the
// seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package j2s_pkg;

   // clamp point and day split
   localparam logic signed [31:0] MIN_SECS   = -32'sd43200;
   localparam logic signed [32:0] HALF_DAY_S = 33'sd43200;
   localparam logic [16:0]        DAY_S      = 17'd86400;
   localparam int unsigned        DAY_SH     = 7;           // 86400 = 675 << 7
   localparam logic [21:0]        JDN_BIAS   = 22'(2451545 + 68569);

   localparam logic [17:0] ERA_D    = 18'd146097;
   localparam logic [11:0] YEAR_MUL = 12'd4000;
   localparam logic [10:0] YEAR_D   = 11'd1461;
   localparam logic [11:0] HOUR_S   = 12'd3600;
   localparam logic [5:0]  MIN_S    = 6'd60;
   localparam logic [13:0] YEAR_BASE = 14'd6900;   // 4900 + 2000

   // floor(a / D) == (a * ceil(2^K / D)) >> K, exact for a < 2^(K - clog2(D))
   localparam int unsigned SH_DAY  = 35;
   localparam int unsigned SH_ERA  = 42;
   localparam int unsigned SH_HOUR = 29;
   localparam int unsigned SH_YEAR = 49;
   localparam int unsigned SH_MIN  = 18;
   localparam int unsigned SH_MON  = 29;

   localparam logic [63:0] RCP_DAY  = ((64'd1 << SH_DAY)  + 64'd674)     / 64'd675;
   localparam logic [63:0] RCP_ERA  = ((64'd1 << SH_ERA)  + 64'd146096)  / 64'd146097;
   localparam logic [63:0] RCP_HOUR = ((64'd1 << SH_HOUR) + 64'd3599)    / 64'd3600;
   localparam logic [63:0] RCP_YEAR = ((64'd1 << SH_YEAR) + 64'd1461000) / 64'd1461001;
   localparam logic [63:0] RCP_MIN  = ((64'd1 << SH_MIN)  + 64'd59)      / 64'd60;
   localparam logic [63:0] RCP_MON  = ((64'd1 << SH_MON)  + 64'd2446)    / 64'd2447;

   typedef logic [14:0] days_type;
   typedef logic [16:0] rem_type;
   typedef logic [21:0] jdn_type;
   typedef logic [6:0]  era_type;
   typedef logic [15:0] doe_type;
   typedef logic [27:0] yacc_type;
   typedef logic [6:0]  yoe_type;
   typedef logic [9:0]  doy_type;
   typedef logic [3:0]  mon_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   typedef struct packed {
      logic [6:0] year_offset;
      logic [3:0] month;
      logic [4:0] day;
   } date_type;

   // floor(2447 * j / 80), day count ahead of month index j
   function automatic logic [8:0] day_base(input mon_type j);
      logic [8:0] v;
      case (j)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd30;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd91;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd152;
         4'd6:    v = 9'd183;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd244;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd305;
         4'd11:   v = 9'd336;
         4'd12:   v = 9'd367;
         4'd13:   v = 9'd397;
         4'd14:   v = 9'd428;
         4'd15:   v = 9'd458;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### design/j2s_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2s_req_if / j2s_rsp_if: valid/ready channels
// Timestamp request channel and calendar response channel.
// ----------------------------------------------------------------------------
interface j2s_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] seconds_since_epoch;

   modport source (output valid, output seconds_since_epoch, input ready);
   modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface j2s_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] year_offset;
   logic [3:0] month;
   logic [4:0] day;
   logic [4:0] hour;
   logic [5:0] minute;
   logic [5:0] second;

   modport source (output valid, output year_offset, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year_offset, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

### design/j2s_day_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2s_day_split: stages 1 to 3
// Clamp, shift to midnight, split into day count and second of day,
// form the biased day number.
// ----------------------------------------------------------------------------
module j2s_day_split (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [31:0] secs,
   output j2s_pkg::rem_type   rem,
   output j2s_pkg::jdn_type   l0
);
   import j2s_pkg::*;

   logic [31:0]        t_ff, t_in;
   logic signed [32:0] sum;
   days_type           days_ff, days_in;
   rem_type            tlo_ff, tlo_in;
   logic [50:0]        dprod;
   logic [31:0]        dsec;
   rem_type            rem_ff, rem_in;
   jdn_type            l0_ff, l0_in;

   // stage 1: clamp below midnight of day zero
   assign sum  = 33'(secs) + HALF_DAY_S;
   assign t_in = (secs < MIN_SECS) ? 32'd0 : sum[31:0];

   // stage 2: t / 86400 as (t >> 7) / 675
   assign dprod   = 51'(t_ff[31:DAY_SH]) * 51'(RCP_DAY[25:0]);
   assign days_in = dprod[SH_DAY+14:SH_DAY];
   assign tlo_in  = t_ff[16:0];

   // stage 3
   assign dsec   = 32'(days_ff) * 32'(DAY_S);
   assign rem_in = tlo_ff - dsec[16:0];
   assign l0_in  = 22'(days_ff) + JDN_BIAS;

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= t_in;
         days_ff <= days_in;
         tlo_ff  <= tlo_in;
         rem_ff  <= rem_in;
         l0_ff   <= l0_in;
      end
   end

   assign rem = rem_ff;
   assign l0  = l0_ff;

endmodule
`default_nettype wire

### design/j2s_time_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2s_time_split: stages 4 to 7
// Second of day into hour, minute and second.
// ----------------------------------------------------------------------------
module j2s_time_split (
   input  logic              clock,
   input  logic              adv,
   input  j2s_pkg::rem_type  rem,
   output j2s_pkg::tod_type  tod
);
   import j2s_pkg::*;

   logic [34:0] hprod;
   logic [4:0]  s4_hour_ff, s4_hour_in;
   rem_type     s4_rem_ff;
   logic [16:0] hsec;
   logic [4:0]  s5_hour_ff;
   logic [11:0] s5_remh_ff, s5_remh_in;
   logic [24:0] mprod;
   logic [4:0]  s6_hour_ff;
   logic [5:0]  s6_min_ff, s6_min_in;
   logic [11:0] s6_remh_ff;
   logic [11:0] msec;
   tod_type     s7_ff, s7_in;

   assign hprod      = 35'(rem) * 35'(RCP_HOUR[17:0]);
   assign s4_hour_in = hprod[SH_HOUR+4:SH_HOUR];

   assign hsec       = 17'(s4_hour_ff) * 17'(HOUR_S);
   assign s5_remh_in = 12'(s4_rem_ff - hsec);

   assign mprod     = 25'(s5_remh_ff) * 25'(RCP_MIN[12:0]);
   assign s6_min_in = mprod[SH_MIN+5:SH_MIN];

   assign msec = 12'(s6_min_ff) * 12'(MIN_S);
   always_comb begin
      s7_in.hour   = s6_hour_ff;
      s7_in.minute = s6_min_ff;
      s7_in.second = 6'(s6_remh_ff - msec);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_hour_ff <= s4_hour_in;
         s4_rem_ff  <= rem;
         s5_hour_ff <= s4_hour_ff;
         s5_remh_ff <= s5_remh_in;
         s6_hour_ff <= s5_hour_ff;
         s6_min_ff  <= s6_min_in;
         s6_remh_ff <= s5_remh_ff;
         s7_ff      <= s7_in;
      end
   end

   assign tod = s7_ff;

endmodule
`default_nettype wire

### design/j2s_civil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2s_civil: stages 4 to 10
// Biased day number into year offset, month and day (integer method,
// at most one constant division per stage).
// ----------------------------------------------------------------------------
module j2s_civil (
   input  logic              clock,
   input  logic              adv,
   input  j2s_pkg::jdn_type  l0,
   output j2s_pkg::date_type date
);
   import j2s_pkg::*;

   // stage 4: era index
   logic [48:0] nprod;
   era_type     s4_n_ff, s4_n_in;
   jdn_type     s4_l0_ff;
   // stage 5: day of era
   logic [24:0] era;
   logic [24:0] era_r;
   logic [22:0] l1w;
   era_type     s5_n_ff;
   doe_type     s5_l1_ff, s5_l1_in;
   // stage 6
   era_type     s6_n_ff;
   doe_type     s6_l1_ff;
   yacc_type    s6_ai_ff, s6_ai_in;
   // stage 7: year of era
   logic [56:0] iprod;
   era_type     s7_n_ff;
   doe_type     s7_l1_ff;
   yoe_type     s7_i_ff, s7_i_in;
   // stage 8: day of year plus 31
   logic [17:0] yq;
   logic [16:0] l2w;
   era_type     s8_n_ff;
   yoe_type     s8_i_ff;
   doy_type     s8_l2_ff, s8_l2_in;
   // stage 9: month index
   logic [16:0] aj;
   logic [34:0] jprod;
   era_type     s9_n_ff;
   yoe_type     s9_i_ff;
   doy_type     s9_l2_ff;
   mon_type     s9_j_ff, s9_j_in;
   // stage 10
   doy_type     dw;
   logic        c;
   logic [13:0] ysum;
   logic [13:0] ydif;
   date_type    s10_ff, s10_in;

   assign nprod   = 49'({l0, 2'b00}) * 49'(RCP_ERA[24:0]);
   assign s4_n_in = nprod[SH_ERA+6:SH_ERA];

   assign era      = 25'(s4_n_ff) * 25'(ERA_D);
   assign era_r    = era + 25'd3;
   assign l1w      = 23'(s4_l0_ff) - era_r[24:2];
   assign s5_l1_in = l1w[15:0];

   assign s6_ai_in = 28'(17'(s5_l1_ff) + 17'd1) * 28'(YEAR_MUL);

   assign iprod   = 57'(s6_ai_ff) * 57'(RCP_YEAR[28:0]);
   assign s7_i_in = iprod[SH_YEAR+6:SH_YEAR];

   assign yq       = 18'(s7_i_ff) * 18'(YEAR_D);
   assign l2w      = 17'(s7_l1_ff) - 17'(yq[17:2]) + 17'd31;
   assign s8_l2_in = l2w[9:0];

   assign aj      = 17'(s8_l2_ff) * 17'd80;
   assign jprod   = 35'(aj) * 35'(RCP_MON[17:0]);
   assign s9_j_in = jprod[SH_MON+3:SH_MON];

   always_comb begin
      dw   = s9_l2_ff - 10'(day_base(s9_j_ff));
      c    = (s9_j_ff >= 4'd11);
      ysum = 14'(s9_n_ff) * 14'd100 + 14'(s9_i_ff) + 14'(c);
      ydif = ysum - YEAR_BASE;
      s10_in.day         = dw[4:0];
      s10_in.month       = c ? (s9_j_ff - 4'd10) : (s9_j_ff + 4'd2);
      // dates before the base year read as offset zero
      s10_in.year_offset = (ysum < YEAR_BASE) ? 7'd0 : ydif[6:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_n_ff  <= s4_n_in;
         s4_l0_ff <= l0;
         s5_n_ff  <= s4_n_ff;
         s5_l1_ff <= s5_l1_in;
         s6_n_ff  <= s5_n_ff;
         s6_l1_ff <= s5_l1_ff;
         s6_ai_ff <= s6_ai_in;
         s7_n_ff  <= s6_n_ff;
         s7_l1_ff <= s6_l1_ff;
         s7_i_ff  <= s7_i_in;
         s8_n_ff  <= s7_n_ff;
         s8_i_ff  <= s7_i_ff;
         s8_l2_ff <= s8_l2_in;
         s9_n_ff  <= s8_n_ff;
         s9_i_ff  <= s8_i_ff;
         s9_l2_ff <= s8_l2_ff;
         s9_j_ff  <= s9_j_in;
         s10_ff   <= s10_in;
      end
   end

   assign date = s10_ff;

endmodule
`default_nettype wire

### design/j2000_seconds_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// j2000_seconds_to_calendar: J2000 seconds to calendar date and time of day
// Ten-stage pipe, one timestamp per clock unless stalled, one response each.
// ----------------------------------------------------------------------------
// Converts a signed count of seconds since 2000-01-01 12:00 into year
// offset from 2000, month, day, hour, minute and second. Counts before
// 2000-01-01 00:00 are clamped to that instant. The pipeline is ten register
// stages deep, and a new request is taken every cycle when the response side
// is not stalled. Stages 1 to 3 clamp the count and split it into day count
// and second of day (division by 86400 as a shift and a reciprocal multiply);
// stages 4 to 10 run the integer day-number-to-date method, at most one
// constant division per stage, while the time of day is split in stages 4
// to 7 and delayed to line up. The pipeline advances as a whole whenever
// the output register is empty or its response is being taken, so
// req_chan.ready drops only while a finished response waits; nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module j2000_seconds_to_calendar (
   input  logic      clock,
   input  logic      reset,
   j2s_req_if.sink   req_chan,
   j2s_rsp_if.source rsp_chan
);
   import j2s_pkg::*;

   localparam int unsigned DEPTH     = 10;   // total register stages
   localparam int unsigned TOD_DELAY = 3;    // time lane ends at stage 7

   logic             adv;
   logic [DEPTH-1:0] vld_ff, vld_in;
   rem_type          rem;
   jdn_type          l0;
   tod_type          tod;
   date_type         date;
   tod_type          tod_ff [TOD_DELAY];

   // whole pipe moves when the output slot frees up this cycle
   assign adv            = !vld_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // valid bits follow the data, one per stage
   assign vld_in = {vld_ff[DEPTH-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   j2s_day_split u_day_split (
      .clock (clock),
      .adv   (adv),
      .secs  (req_chan.seconds_since_epoch),
      .rem   (rem),
      .l0    (l0)
   );

   j2s_time_split u_time_split (
      .clock (clock),
      .adv   (adv),
      .rem   (rem),
      .tod   (tod)
   );

   j2s_civil u_civil (
      .clock (clock),
      .adv   (adv),
      .l0    (l0),
      .date  (date)
   );

   // align time of day with the date lane (stages 8 to 10)
   always_ff @(posedge clock) begin
      if (adv) begin
         tod_ff[0] <= tod;
         for (int s = 1; s < TOD_DELAY; s++) begin
            tod_ff[s] <= tod_ff[s-1];
         end
      end
   end

   assign rsp_chan.valid       = vld_ff[DEPTH-1];
   assign rsp_chan.year_offset = date.year_offset;
   assign rsp_chan.month       = date.month;
   assign rsp_chan.day         = date.day;
   assign rsp_chan.hour        = tod_ff[TOD_DELAY-1].hour;
   assign rsp_chan.minute      = tod_ff[TOD_DELAY-1].minute;
   assign rsp_chan.second      = tod_ff[TOD_DELAY-1].second;

endmodule
`default_nettype wire

### test/tb_j2000_seconds_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_j2000_seconds_to_calendar: self-checking bench for the J2000 converter
// A short table of directed timestamps, then random timestamps skewed toward
// day boundaries and the clamp point. Both channels stall at random. Each
// response is checked field by field against a typed answer or calendar model.
// ----------------------------------------------------------------------------
module tb_j2000_seconds_to_calendar;

   localparam int RAND_ITEMS  = 1500;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 24;       // pipeline is ten stages deep
   localparam int IDLE_PCT    = 37;
   localparam int STEADY_LO   = 700;      // random items with no idling
   localparam int STEADY_HI   = 1000;
   localparam int DIR_N       = 20;

   localparam longint HALF_DAY = 43200;
   localparam longint DAY_SECS = 86400;

   // one response as the block should produce it
   typedef struct packed {
      logic [6:0] year_offset;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } calendar_type;

   // directed row: typed marks a row whose answer is written out here
   typedef struct packed {
      logic signed [31:0] secs;
      bit                 typed;
      calendar_type       want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   j2s_req_if req_bus ();
   j2s_rsp_if rsp_bus ();

   j2000_seconds_to_calendar u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   calendar_type calendar_q [$];   // expected responses, oldest first
   int           mismatches  = 0;
   int           cycle_count = 0;
   bit           no_idle     = 1'b0;   // both sides stream without gaps

   // Directed timestamps. Clamp cases, epoch neighbors and the top count are
   // typed in; leap days and year ends go through the model.
   dir_row_type dir_table [0:DIR_N-1] = '{
      '{-32'sd43200,     1'b1, '{7'd0,  4'd1, 5'd1,  5'd0,  6'd0,  6'd0}},
      '{-32'sd43201,     1'b1, '{7'd0,  4'd1, 5'd1,  5'd0,  6'd0,  6'd0}},
      '{32'sh80000000,   1'b1, '{7'd0,  4'd1, 5'd1,  5'd0,  6'd0,  6'd0}},
      '{32'shAAAAAAAA,   1'b1, '{7'd0,  4'd1, 5'd1,  5'd0,  6'd0,  6'd0}},
      '{-32'sd1,         1'b1, '{7'd0,  4'd1, 5'd1,  5'd11, 6'd59, 6'd59}},
      '{32'sd0,          1'b1, '{7'd0,  4'd1, 5'd1,  5'd12, 6'd0,  6'd0}},
      '{32'sd1,          1'b1, '{7'd0,  4'd1, 5'd1,  5'd12, 6'd0,  6'd1}},
      '{32'sd43199,      1'b1, '{7'd0,  4'd1, 5'd1,  5'd23, 6'd59, 6'd59}},
      '{32'sd43200,      1'b1, '{7'd0,  4'd1, 5'd2,  5'd0,  6'd0,  6'd0}},
      '{32'sh7FFFFFFF,   1'b1, '{7'd68, 4'd1, 5'd19, 5'd15, 6'd14, 6'd7}},
      '{32'sd5054400,    1'b0, '0},   // leap day of 2000
      '{32'sd5140800,    1'b0, '0},   // first of March 2000
      '{32'sd31579199,   1'b0, '0},   // last second of 2000
      '{32'sd31579200,   1'b0, '0},   // first second of 2001
      '{32'sd131284800,  1'b0, '0},   // leap day of 2004
      '{32'sh7FFFFFFE,   1'b0, '0},
      '{32'sh40000000,   1'b0, '0},
      '{32'sh55555555,   1'b0, '0},
      '{32'sd2147472000, 1'b0, '0},
      '{32'sd1234567890, 1'b0, '0}
   };

   // Seconds since J2000 to calendar: clamp, split into day count and
   // second of day, then the integer day-number-to-date method.
   function automatic calendar_type predict_calendar(input logic signed [31:0] secs);
      longint            s;
      longint unsigned   t, days, rem, jdn, l, n, i, j, k, c, year;
      calendar_type      r;
      s = longint'(secs);
      if (s < -HALF_DAY)
         s = -HALF_DAY;
      t    = longint'(s + HALF_DAY);
      days = t / DAY_SECS;
      rem  = t % DAY_SECS;
      jdn  = 64'd2451545 + days;
      l    = jdn + 64'd68569;
      n    = (64'd4 * l) / 64'd146097;
      l    = l - (64'd146097 * n + 64'd3) / 64'd4;
      i    = (64'd4000 * (l + 64'd1)) / 64'd1461001;
      l    = l - (64'd1461 * i) / 64'd4 + 64'd31;
      j    = (64'd80 * l) / 64'd2447;
      k    = l - (64'd2447 * j) / 64'd80;
      c    = j / 64'd11;
      year = 64'd100 * n + i + c - 64'd4900;
      r.year_offset = (year >= 64'd2000) ? 7'(year - 64'd2000) : 7'd0;
      r.month       = 4'(j + 64'd2 - 64'd12 * c);
      r.day         = 5'(k);
      r.hour        = 5'(rem / 64'd3600);
      r.minute      = 6'((rem % 64'd3600) / 64'd60);
      r.second      = 6'(rem % 64'd60);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("t=%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Present one timestamp, idling first at random, and hold it until the
   // transfer. The expectation is queued on the accepting edge.
   task automatic send_timestamp(input logic signed [31:0] secs, input bit typed,
                                 input calendar_type want);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid               <= 1'b0;
         req_bus.seconds_since_epoch <= $urandom;   // junk while idle
         @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.seconds_since_epoch <= secs;
      do
         @(posedge clock);
      while (!req_bus.ready);
      calendar_q.push_back(typed ? want : predict_calendar(secs));
   endtask

   // Random timestamp: full 32-bit noise, day edges, the clamp edge, or a
   // uniform pick over the legal range.
   function automatic logic signed [31:0] random_timestamp();
      int     pick;
      longint v;
      pick = $urandom_range(99);
      if (pick < 35)
         v = longint'($signed($urandom));
      else if (pick < 60)
         v = longint'($urandom_range(24854)) * DAY_SECS - HALF_DAY
             + longint'($urandom_range(6)) - 3;
      else if (pick < 75)
         v = -HALF_DAY + longint'($urandom_range(20)) - 10;
      else
         v = longint'($urandom_range(32'd2147526847)) - HALF_DAY;
      return v[31:0];
   endfunction

   // Response side: random back-pressure, and the check on every transfer.
   always @(posedge clock) begin
      calendar_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (calendar_q.size() == 0) begin
               report_mismatch("response with nothing pending", 0, 0);
            end else begin
               want = calendar_q.pop_front();
               if (rsp_bus.year_offset !== want.year_offset)
                  report_mismatch("year_offset", int'(rsp_bus.year_offset),
                                  int'(want.year_offset));
               if (rsp_bus.month !== want.month)
                  report_mismatch("month", int'(rsp_bus.month), int'(want.month));
               if (rsp_bus.day !== want.day)
                  report_mismatch("day", int'(rsp_bus.day), int'(want.day));
               if (rsp_bus.hour !== want.hour)
                  report_mismatch("hour", int'(rsp_bus.hour), int'(want.hour));
               if (rsp_bus.minute !== want.minute)
                  report_mismatch("minute", int'(rsp_bus.minute), int'(want.minute));
               if (rsp_bus.second !== want.second)
                  report_mismatch("second", int'(rsp_bus.second), int'(want.second));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[j2000_seconds_to_calendar] ERROR");
         $finish;
      end
   end

   initial begin
      // known values on the request side before the first edge
      reset                       = 1'b1;
      req_bus.valid               = 1'b0;
      req_bus.seconds_since_epoch = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_N; r++)
         send_timestamp(dir_table[r].secs, dir_table[r].typed, dir_table[r].want);

      // random part, with a gap-free stretch in the middle
      for (int n = 0; n < RAND_ITEMS; n++) begin
         no_idle = (n >= STEADY_LO) && (n < STEADY_HI);
         send_timestamp(random_timestamp(), 1'b0, '0);
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      // drain: every expected response in, then a wait for strays
      while (calendar_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && calendar_q.size() == 0)
         $display("[j2000_seconds_to_calendar] OK");
      else
         $display("[j2000_seconds_to_calendar] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
